// File: rtl/core/first_fit_heap_allocator_core_macros.svh
// Assertion macros for the first-fit heap allocator core.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_CORE_MACROS_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_CORE_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, sampled on clk_i, off during reset.
`define FFA_ASSERT_NOW(lbl, a, b) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |-> (b)) \
    else $error("ffa assertion failed");
// Next-cycle implication, sampled on clk_i, off during reset.
`define FFA_ASSERT_NEXT(lbl, a, b) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |=> (b)) \
    else $error("ffa assertion failed");
`else
`define FFA_ASSERT_NOW(lbl, a, b)
`define FFA_ASSERT_NEXT(lbl, a, b)
`endif
`endif

// File: rtl/core/ffa_pkg.sv
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared codes, state encoding and controller/datapath interface types.
// ----------------------------------------------------------------------------
package ffa_pkg;

  localparam logic [1:0] FN_ALLOC = 2'd0;
  localparam logic [1:0] FN_FREE  = 2'd1;
  localparam logic [1:0] FN_RESET = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOFIT   = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_UNKNOWN = 2'd3;

  localparam logic CFG_HEAP_BASE  = 1'b0;
  localparam logic CFG_HEAP_BYTES = 1'b1;

  localparam logic [31:0] RST_HEAP_BASE  = 32'd3000000000;
  localparam logic [31:0] RST_HEAP_BYTES = 32'd1000000000;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_INIT, S_FIT, S_SLOT, S_ACOMMIT,
    S_LREAD, S_LCMP, S_POS, S_FCOMMIT, S_DONE
  } ffa_state_e;

  typedef enum logic [3:0] {
    OP_NONE, OP_CAPTURE, OP_INIT, OP_FIT_STEP, OP_SLOT_STEP, OP_ALLOC_COMMIT,
    OP_LIVE_READ, OP_LIVE_CMP, OP_POS_STEP, OP_FREE_COMMIT, OP_PUSH
  } ffa_op_e;

  typedef struct packed {
    ffa_op_e    op;
    logic [1:0] res;
  } ffa_cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       rel_zero;
    logic       seg_end;
    logic       fit_hit;
    logic       slot_end;
    logic       slot_free;
    logic       live_match;
    logic       pos_hit;
    logic       can_free;
    logic       out_busy;
  } ffa_sts_t;

endpackage

// File: rtl/core/ffa_ctrl.sv
// ----------------------------------------------------------------------------
// ffa_ctrl
// Sequencer that walks the free and live tables one entry per step.
// ----------------------------------------------------------------------------
module ffa_ctrl import ffa_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  ffa_sts_t sts_i,
  output ffa_cmd_t cmd_o
);

  ffa_state_e state_q, state_d;
  logic [1:0] res_q, res_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      res_q   <= ST_OK;
    end else begin
      state_q <= state_d;
      res_q   <= res_d;
    end
  end

  always_comb begin
    state_d = state_q;
    res_d   = res_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DECODE;
      end
      S_DECODE: begin
        res_d = ST_OK;
        case (sts_i.func)
          FN_ALLOC: state_d = S_FIT;
          FN_FREE:  state_d = sts_i.rel_zero ? S_DONE : S_LREAD;
          FN_RESET: state_d = S_INIT;
          default:  state_d = S_DONE;
        endcase
      end
      S_INIT: state_d = S_DONE;
      S_FIT: begin
        if (sts_i.seg_end) begin
          res_d   = ST_NOFIT;
          state_d = S_DONE;
        end else if (sts_i.fit_hit) begin
          state_d = S_SLOT;
        end
      end
      S_SLOT: begin
        if (sts_i.slot_end) begin
          res_d   = ST_FULL;
          state_d = S_DONE;
        end else if (sts_i.slot_free) begin
          state_d = S_ACOMMIT;
        end
      end
      S_ACOMMIT: state_d = S_DONE;
      S_LREAD: begin
        if (sts_i.slot_end) begin
          res_d   = ST_UNKNOWN;
          state_d = S_DONE;
        end else begin
          state_d = S_LCMP;
        end
      end
      S_LCMP:  state_d = sts_i.live_match ? S_POS : S_LREAD;
      S_POS: begin
        if (sts_i.pos_hit) state_d = S_FCOMMIT;
      end
      S_FCOMMIT: begin
        res_d   = sts_i.can_free ? ST_OK : ST_FULL;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!sts_i.out_busy) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o.op   = OP_NONE;
    cmd_o.res  = res_q;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.op = OP_CAPTURE;
      end
      S_INIT:    cmd_o.op = OP_INIT;
      S_FIT:     cmd_o.op = OP_FIT_STEP;
      S_SLOT:    cmd_o.op = OP_SLOT_STEP;
      S_ACOMMIT: cmd_o.op = OP_ALLOC_COMMIT;
      S_LREAD:   cmd_o.op = OP_LIVE_READ;
      S_LCMP:    cmd_o.op = OP_LIVE_CMP;
      S_POS:     cmd_o.op = OP_POS_STEP;
      S_FCOMMIT: cmd_o.op = OP_FREE_COMMIT;
      S_DONE: begin
        if (!sts_i.out_busy) cmd_o.op = OP_PUSH;
      end
      default:   cmd_o.op = OP_NONE;
    endcase
  end

endmodule

// File: rtl/core/ffa_dp.sv
// ----------------------------------------------------------------------------
// ffa_dp
// Free segment table, live block store, scan counters and result register.
// ----------------------------------------------------------------------------
module ffa_dp import ffa_pkg::*; #(
  parameter int MAX_SEGMENTS = 16,
  parameter int MAX_LIVE     = 32,
  parameter int HEADER_BYTES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic [1:0]  func_i,
  input  logic [31:0] request_bytes_i,
  input  logic [31:0] release_addr_i,
  input  ffa_cmd_t    cmd_i,
  output ffa_sts_t    sts_o,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output logic [31:0] block_addr_o,
  output logic [1:0]  status_o
);

  localparam int SIW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int SCW = $clog2(MAX_SEGMENTS + 1);
  localparam int LIW = (MAX_LIVE > 1) ? $clog2(MAX_LIVE) : 1;
  localparam int LCW = $clog2(MAX_LIVE + 1);
  localparam logic [33:0] HDR34 = 34'(HEADER_BYTES);
  localparam logic [31:0] HDR32 = 32'(HEADER_BYTES);

  logic [31:0] base_q, bytes_q;
  logic [1:0]  func_q;
  logic [33:0] total_q;
  logic [31:0] rel_q;
  logic [31:0] fs_q [MAX_SEGMENTS];
  logic [31:0] fl_q [MAX_SEGMENTS];
  logic [31:0] fs_d [MAX_SEGMENTS];
  logic [31:0] fl_d [MAX_SEGMENTS];
  logic [31:0] fs_up [MAX_SEGMENTS];
  logic [31:0] fl_up [MAX_SEGMENTS];
  logic [31:0] fs_dn [MAX_SEGMENTS];
  logic [31:0] fl_dn [MAX_SEGMENTS];
  logic [SCW-1:0] cnt_q, cnt_d;
  logic [SCW-1:0] sidx_q;
  logic [LCW-1:0] lidx_q;
  logic [32:0] prev_end_q;
  logic [31:0] prev_start_q, prev_len_q;
  logic [31:0] blen_q;
  logic [MAX_LIVE-1:0] valid_q;
  logic [31:0] lm_addr [MAX_LIVE];
  logic [31:0] lm_len [MAX_LIVE];
  logic [31:0] rd_addr_q, rd_len_q;
  logic [31:0] res_addr_q;
  logic        out_valid_q;
  logic [31:0] out_addr_q;
  logic [1:0]  out_st_q;

  logic [31:0] cur_s, cur_l, bstart, alloc_blen;
  logic        seg_end, fit_hit, slot_end, slot_free, live_match, pos_hit;
  logic        left, right, can_free, split;
  logic        set_en, ins_en, rem_en;
  logic [SIW-1:0] set_idx, sh_idx;
  logic [31:0] set_s, set_l;
  logic [32:0] room;
  logic [31:0] clip_len;

  assign cur_s      = fs_q[sidx_q[SIW-1:0]];
  assign cur_l      = fl_q[sidx_q[SIW-1:0]];
  assign seg_end    = (sidx_q == cnt_q);
  assign fit_hit    = !seg_end && ({2'b00, cur_l} >= total_q);
  assign slot_end   = (lidx_q == LCW'(MAX_LIVE));
  assign slot_free  = !valid_q[lidx_q[LIW-1:0]];
  assign live_match = valid_q[lidx_q[LIW-1:0]] && (rd_addr_q == rel_q);
  assign bstart     = rel_q - HDR32;
  assign pos_hit    = seg_end || (cur_s >= bstart);
  assign left       = (sidx_q != '0) && (prev_end_q == {1'b0, bstart});
  assign right      = !seg_end && ({1'b0, cur_s} == ({1'b0, bstart} + {1'b0, blen_q}));
  assign can_free   = left || right || (cnt_q < SCW'(MAX_SEGMENTS));
  assign split      = {2'b00, cur_l} > (total_q + HDR34);
  assign alloc_blen = split ? total_q[31:0] : cur_l;
  assign room       = 33'h1_0000_0000 - {1'b0, base_q};
  assign clip_len   = ({1'b0, bytes_q} > room) ? room[31:0] : bytes_q;

  assign sts_o.func       = func_q;
  assign sts_o.rel_zero   = (rel_q == '0);
  assign sts_o.seg_end    = seg_end;
  assign sts_o.fit_hit    = fit_hit;
  assign sts_o.slot_end   = slot_end;
  assign sts_o.slot_free  = slot_free;
  assign sts_o.live_match = live_match;
  assign sts_o.pos_hit    = pos_hit;
  assign sts_o.can_free   = can_free;
  assign sts_o.out_busy   = out_valid_q && !out_ready_i;

  // Neighbor views of the table, used to shift it by one entry.
  for (genvar k = 0; k < MAX_SEGMENTS; k++) begin : g_nb
    if (k < MAX_SEGMENTS - 1) begin : g_up
      assign fs_up[k] = fs_q[k+1];
      assign fl_up[k] = fl_q[k+1];
    end else begin : g_top
      assign fs_up[k] = '0;
      assign fl_up[k] = '0;
    end
    if (k > 0) begin : g_dn
      assign fs_dn[k] = fs_q[k-1];
      assign fl_dn[k] = fl_q[k-1];
    end else begin : g_bot
      assign fs_dn[k] = '0;
      assign fl_dn[k] = '0;
    end
  end

  // Table edit command for this cycle.
  always_comb begin
    set_en  = 1'b0;
    ins_en  = 1'b0;
    rem_en  = 1'b0;
    set_idx = sidx_q[SIW-1:0];
    sh_idx  = sidx_q[SIW-1:0];
    set_s   = bstart;
    set_l   = blen_q;
    cnt_d   = cnt_q;
    case (cmd_i.op)
      OP_INIT: begin
        set_en  = 1'b1;
        set_idx = '0;
        set_s   = base_q;
        set_l   = clip_len;
        cnt_d   = (clip_len != '0) ? SCW'(1) : '0;
      end
      OP_ALLOC_COMMIT: begin
        if (split) begin
          set_en = 1'b1;
          set_s  = cur_s + total_q[31:0];
          set_l  = cur_l - total_q[31:0];
        end else begin
          rem_en = 1'b1;
          cnt_d  = cnt_q - SCW'(1);
        end
      end
      OP_FREE_COMMIT: begin
        if (left && right) begin
          set_en  = 1'b1;
          set_idx = sidx_q[SIW-1:0] - SIW'(1);
          set_s   = prev_start_q;
          set_l   = prev_len_q + blen_q + cur_l;
          rem_en  = 1'b1;
          cnt_d   = cnt_q - SCW'(1);
        end else if (left) begin
          set_en  = 1'b1;
          set_idx = sidx_q[SIW-1:0] - SIW'(1);
          set_s   = prev_start_q;
          set_l   = prev_len_q + blen_q;
        end else if (right) begin
          set_en = 1'b1;
          set_l  = cur_l + blen_q;
        end else if (can_free) begin
          set_en = 1'b1;
          ins_en = 1'b1;
          cnt_d  = cnt_q + SCW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    for (int k = 0; k < MAX_SEGMENTS; k++) begin
      fs_d[k] = fs_q[k];
      fl_d[k] = fl_q[k];
      if (rem_en && (SIW'(k) >= sh_idx)) begin
        fs_d[k] = fs_up[k];
        fl_d[k] = fl_up[k];
      end
      if (ins_en && (SIW'(k) > sh_idx)) begin
        fs_d[k] = fs_dn[k];
        fl_d[k] = fl_dn[k];
      end
      if (set_en && (SIW'(k) == set_idx)) begin
        fs_d[k] = set_s;
        fl_d[k] = set_l;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MAX_SEGMENTS; k++) begin
        fs_q[k] <= '0;
        fl_q[k] <= '0;
      end
      fs_q[0] <= RST_HEAP_BASE;
      fl_q[0] <= RST_HEAP_BYTES;
      cnt_q   <= SCW'(1);
      base_q  <= RST_HEAP_BASE;
      bytes_q <= RST_HEAP_BYTES;
      valid_q <= '0;
      sidx_q  <= '0;
      lidx_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fs_q  <= fs_d;
      fl_q  <= fl_d;
      cnt_q <= cnt_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_HEAP_BASE) base_q <= cfg_wdata_i;
        else bytes_q <= cfg_wdata_i;
      end
      // A push may land in the cycle the previous result leaves.
      if (cmd_i.op == OP_PUSH) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (cmd_i.op)
        OP_CAPTURE: begin
          sidx_q <= '0;
          lidx_q <= '0;
        end
        OP_INIT: valid_q <= '0;
        OP_FIT_STEP: begin
          if (!seg_end && !fit_hit) sidx_q <= sidx_q + SCW'(1);
        end
        OP_SLOT_STEP: begin
          if (!slot_end && !slot_free) lidx_q <= lidx_q + LCW'(1);
        end
        OP_ALLOC_COMMIT: valid_q[lidx_q[LIW-1:0]] <= 1'b1;
        OP_LIVE_CMP: begin
          if (!live_match) lidx_q <= lidx_q + LCW'(1);
        end
        OP_POS_STEP: begin
          if (!pos_hit) sidx_q <= sidx_q + SCW'(1);
        end
        OP_FREE_COMMIT: begin
          if (can_free) valid_q[lidx_q[LIW-1:0]] <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_CAPTURE: begin
        func_q     <= func_i;
        rel_q      <= release_addr_i;
        total_q    <= ((({2'b00, request_bytes_i}) + 34'd7) & ~34'd7) + HDR34;
        res_addr_q <= '0;
      end
      OP_ALLOC_COMMIT: res_addr_q <= cur_s + HDR32;
      OP_LIVE_CMP: begin
        if (live_match) blen_q <= rd_len_q;
      end
      OP_POS_STEP: begin
        if (!pos_hit) begin
          prev_end_q   <= {1'b0, cur_s} + {1'b0, cur_l};
          prev_start_q <= cur_s;
          prev_len_q   <= cur_l;
        end
      end
      OP_PUSH: begin
        out_addr_q <= res_addr_q;
        out_st_q   <= cmd_i.res;
      end
      default: begin
      end
    endcase
  end

  // Live block store: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_ALLOC_COMMIT) begin
      lm_addr[lidx_q[LIW-1:0]] <= cur_s + HDR32;
      lm_len[lidx_q[LIW-1:0]]  <= alloc_blen;
    end
    if (cmd_i.op == OP_LIVE_READ) begin
      rd_addr_q <= lm_addr[lidx_q[LIW-1:0]];
      rd_len_q  <= lm_len[lidx_q[LIW-1:0]];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign block_addr_o = out_addr_q;
  assign status_o     = out_st_q;

endmodule

// File: rtl/core/first_fit_heap_allocator_core.sv
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_core
// First-fit heap allocator with coalescing over one address region.
// ----------------------------------------------------------------------------
// Usage: one request transaction (func, request_bytes, release_addr) is taken
// on the input channel when in_valid_i and in_ready_o are high; exactly one
// result transaction (block_addr, status) follows on the output channel.
// The block handles one request at a time. An allocate walks the free table
// one segment per cycle and then the live valid bits one per cycle. A free
// reads the live store through its single registered port, with a read state
// and a compare state per slot, then walks the free table to the insert point.
// Reset heap and no-op requests do no table scan. The scans of the tables
// set how long an allocate or a free takes.
// A finished result sits in an output register; the next request is taken
// while it waits, and a stalled receiver only holds the following result.
// Reset leaves the registers at their defaults and the free table holding
// the whole default heap; heap_base and heap_bytes take effect at reset heap.
// ----------------------------------------------------------------------------
`include "first_fit_heap_allocator_core_macros.svh"

module first_fit_heap_allocator_core import ffa_pkg::*; #(
  parameter int MAX_SEGMENTS = 16,
  parameter int MAX_LIVE     = 32,
  parameter int HEADER_BYTES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [31:0] request_bytes_i,
  input  logic [31:0] release_addr_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] block_addr_o,
  output logic [1:0]  status_o
);

  ffa_cmd_t cmd;
  ffa_sts_t sts;

  ffa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ffa_dp #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .MAX_LIVE     (MAX_LIVE),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .func_i          (func_i),
    .request_bytes_i (request_bytes_i),
    .release_addr_i  (release_addr_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .block_addr_o    (block_addr_o),
    .status_o        (status_o)
  );

  // Any failed request reports no address.
  `FFA_ASSERT_NOW(a_err_no_addr, out_valid_o && (status_o != ST_OK), block_addr_o == '0)
  // Once a transaction is taken the block is busy on the next cycle.
  `FFA_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o)
  // A result is only loaded while the output register is free.
  `FFA_ASSERT_NOW(a_push_free, cmd.op == OP_PUSH, !(out_valid_o && !out_ready_i))

endmodule
